@@ hdl/ipwf_pkg.sv @@
package ipwf_pkg;

    localparam int MaxRulesDefault = 16;

    localparam logic [31:0] ANY_ADDR = 32'hFFFF_FFFF;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } t_in;

    typedef struct packed {
        logic verdict;
        logic status;
    } t_out;

    // token that walks the cell chain, one cell per cycle while the chain advances
    typedef struct packed {
        logic        is_add;
        logic        is_check;
        logic        hit;
        logic        status;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } t_tok;

endpackage

@@ hdl/ipwf_head.sv @@
module ipwf_head
    import ipwf_pkg::*;
#(
    parameter int MAX_RULES = MaxRulesDefault,
    localparam int CW = $clog2(MAX_RULES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_in_valid,
    input  t_in           i_in_data,
    output logic          o_v,
    output t_tok          o_tok,
    output logic [CW-1:0] o_cnt
);

    logic [CW-1:0] r_count, n_count;
    logic          r_v;
    t_tok          r_tok, n_tok;
    logic [CW-1:0] r_cnt;
    logic          w_acc;
    logic          w_full;

    assign w_acc  = i_in_valid && i_adv;
    assign w_full = (r_count == CW'(MAX_RULES));

    always_comb begin
        n_count        = r_count;
        n_tok.is_add   = 1'b0;
        n_tok.is_check = 1'b0;
        n_tok.hit      = 1'b0;
        n_tok.status   = 1'b0;
        n_tok.src_addr = i_in_data.src_addr;
        n_tok.dst_addr = i_in_data.dst_addr;
        case (i_in_data.command)
            CMD_ADD: begin
                if (w_full) begin
                    n_tok.status = 1'b1;
                end else begin
                    n_tok.is_add = 1'b1;
                    n_count      = r_count + CW'(1);
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_CHECK: begin
                n_tok.is_check = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_v     <= 1'b0;
        end else if (i_adv) begin
            r_v <= i_in_valid;
            if (w_acc) begin
                r_count <= n_count;
            end
        end
    end

    // count at entry: write slot for an add, active depth for a check
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_tok <= n_tok;
            r_cnt <= r_count;
        end
    end

    assign o_v   = r_v;
    assign o_tok = r_tok;
    assign o_cnt = r_cnt;

endmodule

@@ hdl/ipwf_cell.sv @@
module ipwf_cell
    import ipwf_pkg::*;
#(
    parameter int MAX_RULES = MaxRulesDefault,
    parameter int INDEX = 0,
    localparam int CW = $clog2(MAX_RULES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_v,
    input  t_tok          i_tok,
    input  logic [CW-1:0] i_cnt,
    output logic          o_v,
    output t_tok          o_tok,
    output logic [CW-1:0] o_cnt
);

    logic [31:0]   r_src;
    logic [31:0]   r_dst;
    logic          r_v;
    t_tok          r_tok, n_tok;
    logic [CW-1:0] r_cnt;
    logic          w_here;
    logic          w_active;
    logic          w_match;

    assign w_here   = (i_cnt == CW'(INDEX));
    assign w_active = (CW'(INDEX) < i_cnt);
    assign w_match  = ((r_src == i_tok.src_addr) || (r_src == ANY_ADDR)) &&
                      ((r_dst == i_tok.dst_addr) || (r_dst == ANY_ADDR));

    always_comb begin
        n_tok     = i_tok;
        n_tok.hit = i_tok.hit | (i_tok.is_check & w_active & w_match);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_adv) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
            r_cnt <= i_cnt;
        end
        if (i_adv && i_v && i_tok.is_add && w_here) begin
            r_src <= i_tok.src_addr;
            r_dst <= i_tok.dst_addr;
        end
    end

    assign o_v   = r_v;
    assign o_tok = r_tok;
    assign o_cnt = r_cnt;

endmodule

@@ hdl/ip_pair_wildcard_filter_core.sv @@
// channel | handshake                | beat
// in      | i_in_valid / o_in_ready  | i_in_data  (t_in: command, src_addr, dst_addr)
// out     | o_out_valid / i_out_ready| o_out_data (t_out: verdict, status)
//
// One beat accepted per cycle while the output is not held. The head register
// loads on the accepting edge, and the beat then steps through the rule cells
// in index order; the result beat is valid at the output of the last cell.
// Rule count is cleared by reset; rule storage is not, and needs no pass.
// A result held at the output freezes the whole cell chain and the input.
module ip_pair_wildcard_filter_core
    import ipwf_pkg::*;
#(
    parameter int MAX_RULES = MaxRulesDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int CW = $clog2(MAX_RULES + 1);

    logic          w_adv;
    logic          w_v   [MAX_RULES+1];
    t_tok          w_tok [MAX_RULES+1];
    logic [CW-1:0] w_cnt [MAX_RULES+1];

    assign w_adv      = !w_v[MAX_RULES] || i_out_ready;
    assign o_in_ready = w_adv;

    ipwf_head #(
        .MAX_RULES(MAX_RULES)
    ) u_head (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_in_valid(i_in_valid),
        .i_in_data (i_in_data),
        .o_v       (w_v[0]),
        .o_tok     (w_tok[0]),
        .o_cnt     (w_cnt[0])
    );

    for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
        ipwf_cell #(
            .MAX_RULES(MAX_RULES),
            .INDEX    (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (w_adv),
            .i_v    (w_v[g]),
            .i_tok  (w_tok[g]),
            .i_cnt  (w_cnt[g]),
            .o_v    (w_v[g+1]),
            .o_tok  (w_tok[g+1]),
            .o_cnt  (w_cnt[g+1])
        );
    end

    assign o_out_valid        = w_v[MAX_RULES];
    assign o_out_data.verdict = w_tok[MAX_RULES].hit;
    assign o_out_data.status  = w_tok[MAX_RULES].status;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v[0] |-> (w_cnt[0] <= CW'(MAX_RULES)))
        else $error("rule count beyond table depth");

    a_add_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v[0] && w_tok[0].is_add) |-> (w_cnt[0] < CW'(MAX_RULES)))
        else $error("add token aimed past the last cell");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.verdict && o_out_data.status))
        else $error("drop and full reported on one beat");

    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v[0] && !w_adv) |=> (w_v[0] && $stable(w_cnt[0])))
        else $error("head stage moved during a stall");
`endif

endmodule

@@ bench/testbench.sv @@
module testbench;
    import ipwf_pkg::*;

    localparam int RULES       = MaxRulesDefault;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 3 * (RULES + 1);
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic i_in_valid = 1'b0;
    t_in  i_in_data  = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    ip_pair_wildcard_filter_core #(
        .MAX_RULES(RULES)
    ) dut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_in_valid                (i_in_valid),
        .i_in_data                 (i_in_data),
        .o_in_ready                (o_in_ready),
        .o_out_valid               (o_out_valid),
        .i_out_ready               (i_out_ready),
        .o_out_data                (o_out_data)
    );

    // shadow of the rule table
    logic [31:0] shadow_src [RULES];
    logic [31:0] shadow_dst [RULES];
    int          shadow_count = 0;

    t_out        expected_verdicts [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          out_stall_pct = 0;
    logic [31:0] addr_pool [8];

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_out filter_verdict(t_in beat);
        t_out res;
        res = '0;
        case (beat.command)
            CMD_ADD: begin
                if (shadow_count < RULES) begin
                    shadow_src[shadow_count] = beat.src_addr;
                    shadow_dst[shadow_count] = beat.dst_addr;
                    shadow_count++;
                end else begin
                    res.status = 1'b1;
                end
            end
            CMD_CLEAR: shadow_count = 0;
            CMD_CHECK: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if ((shadow_src[i] == beat.src_addr || shadow_src[i] == ANY_ADDR) &&
                        (shadow_dst[i] == beat.dst_addr || shadow_dst[i] == ANY_ADDR))
                        res.verdict = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic got, logic want);
        $display("mismatch %s: got %0b want %0b at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // drive one beat, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_beat(logic [1:0] cmd, logic [31:0] src, logic [31:0] dst);
        t_in beat;
        beat.command  = cmd;
        beat.src_addr = src;
        beat.dst_addr = dst;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_data  <= t_in'({$urandom, $urandom, $urandom});
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        expected_verdicts.push_back(filter_verdict(beat));
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("unexpected result beat at cycle %0d", cycle_count);
                mismatch_count++;
            end else begin
                if (o_out_data.verdict !== expected_verdicts[0].verdict)
                    report_mismatch("verdict", o_out_data.verdict, expected_verdicts[0].verdict);
                if (o_out_data.status !== expected_verdicts[0].status)
                    report_mismatch("status", o_out_data.status, expected_verdicts[0].status);
                void'(expected_verdicts.pop_front());
            end
        end
    end

    task automatic test_empty_table();
        send_beat(CMD_UNUSED, ANY_ADDR, ANY_ADDR);
        send_beat(CMD_CHECK, 32'h0, 32'h0);
        send_beat(CMD_CHECK, ANY_ADDR, ANY_ADDR);
    endtask

    task automatic test_wildcards();
        send_beat(CMD_ADD, ANY_ADDR, 32'h0A00_0001);
        send_beat(CMD_ADD, 32'hC0A8_0005, ANY_ADDR);
        send_beat(CMD_CHECK, 32'h1234_5678, 32'h0A00_0001);
        send_beat(CMD_CHECK, 32'hC0A8_0005, 32'h0);
        send_beat(CMD_CHECK, 32'h0, 32'h0);
        send_beat(CMD_ADD, 32'h0, 32'h0);
        send_beat(CMD_ADD, 32'h0, 32'h0);       // duplicate is stored as well
        send_beat(CMD_CHECK, 32'h0, 32'h0);
    endtask

    task automatic test_table_full();
        repeat (RULES - 4) send_beat(CMD_ADD, $urandom, $urandom);
        send_beat(CMD_ADD, 32'hDEAD_BEEF, 32'hFEED_F00D);
        send_beat(CMD_CHECK, 32'hDEAD_BEEF, 32'hFEED_F00D);
        send_beat(CMD_UNUSED, 32'h0, 32'h0);
        send_beat(CMD_CLEAR, ANY_ADDR, ANY_ADDR);
        send_beat(CMD_CHECK, 32'hC0A8_0005, 32'h0A00_0001);
    endtask

    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return addr_pool[$urandom_range(0, 7)];
        if (r < 75) return ANY_ADDR;
        return $urandom;
    endfunction

    // mostly adds and checks over a small address pool so rules hit and the table fills
    task automatic test_random_traffic(int idle_pct, int stall_pct, int n_beats);
        int r;
        logic [1:0] cmd;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        foreach (addr_pool[i]) addr_pool[i] = $urandom;
        repeat (n_beats) begin
            r = $urandom_range(0, 99);
            if (r < 5)       cmd = CMD_CLEAR;
            else if (r < 8)  cmd = CMD_UNUSED;
            else if (r < 45) cmd = CMD_ADD;
            else             cmd = CMD_CHECK;
            send_beat(cmd, pick_addr(), pick_addr());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_wildcards();
        test_table_full();
        test_random_traffic(0, 0, 150);
        test_random_traffic(77, 0, 150);
        test_random_traffic(0, 77, 150);
        test_random_traffic(35, 35, 150);
        i_in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
